/* src/format_spec_usage_scanner_defines.svh */
// ----------------------------------------------------------------------------
// Format spec usage scanner - assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPEC_USAGE_SCANNER_DEFINES_SVH
`define FORMAT_SPEC_USAGE_SCANNER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define FSUS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define FSUS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fsus_pkg.sv */
// ----------------------------------------------------------------------------
// fsus_pkg
// Types, phase codes and the conversion table of the format spec scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fsus_pkg;

    localparam int CH_W    = 8;
    localparam int MASK_W  = 31;
    localparam int LEVEL_W = 2;
    localparam int PHASE_W = 3;
    localparam int TBL_LEN = 21;
    localparam int TDATA_W = 40;

    localparam logic [PHASE_W-1:0] PH_TEXT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PCT     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FLAGS   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_H1      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CONV    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_BRACKET = 3'd6;

    localparam logic [MASK_W-1:0]  WIDTH_BIT = 31'h4000_0000;
    localparam logic [LEVEL_W-1:0] LEVEL_STD = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               long_seen;
        logic [MASK_W-1:0]  mask;
        logic [LEVEL_W-1:0] level;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:     PH_TEXT,
        long_seen: 1'b0,
        mask:      '0,
        level:     2'd1
    };

    typedef struct packed {
        logic [CH_W-1:0]    code;
        logic [LEVEL_W-1:0] level;
        logic [MASK_W-1:0]  short_mask;
        logic [MASK_W-1:0]  long_mask;
    } t_conv_entry;

    // table lookup result handed to the parser
    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
        logic [MASK_W-1:0]  short_mask;
        logic [MASK_W-1:0]  long_mask;
    } t_conv_hit;

    localparam t_conv_entry CONV_TBL [TBL_LEN] = '{
        '{8'h64, 2'd1, 31'h0000_0001, 31'h0000_1000},  // d
        '{8'h75, 2'd1, 31'h0000_0002, 31'h0000_2000},  // u
        '{8'h78, 2'd2, 31'h0000_0004, 31'h0000_4000},  // x
        '{8'h58, 2'd2, 31'h0000_0008, 31'h0000_8000},  // X
        '{8'h6F, 2'd2, 31'h0000_0010, 31'h0001_0000},  // o
        '{8'h6E, 2'd2, 31'h0000_0020, 31'h0002_0000},  // n
        '{8'h69, 2'd2, 31'h0000_0040, 31'h0004_0000},  // i
        '{8'h70, 2'd2, 31'h0000_0080, 31'h0008_0000},  // p
        '{8'h42, 2'd2, 31'h0000_0100, 31'h0010_0000},  // B
        '{8'h73, 2'd1, 31'h0000_0200, 31'h0000_0000},  // s
        '{8'h53, 2'd3, 31'h0200_0200, 31'h0000_0000},  // S
        '{8'h63, 2'd1, 31'h0000_0400, 31'h0000_0000},  // c
        '{8'h5B, 2'd0, 31'h0020_0000, 31'h0000_0000},  // [
        '{8'h61, 2'd0, 31'h0040_0000, 31'h0000_0000},  // a
        '{8'h41, 2'd0, 31'h0080_0000, 31'h0000_0000},  // A
        '{8'h65, 2'd3, 31'h0100_0000, 31'h0100_0000},  // e
        '{8'h45, 2'd3, 31'h0200_0000, 31'h0200_0000},  // E
        '{8'h66, 2'd3, 31'h0400_0000, 31'h0400_0000},  // f
        '{8'h46, 2'd3, 31'h0800_0000, 31'h0800_0000},  // F
        '{8'h67, 2'd3, 31'h1000_0000, 31'h1000_0000},  // g
        '{8'h47, 2'd3, 31'h2000_0000, 31'h2000_0000}   // G
    };

endpackage

`default_nettype wire

/* src/format_spec_usage_scanner.sv */
// A zero byte is held in the input register, then its result word is loaded
// into the result register, unless the input stage stalls on a waiting result.
// Throughput: one byte per cycle while the input stage is not stalled; the parser
// state updates in a single pass between the input register and the result register.
// The input stage stalls only when it holds a zero byte while a result waits.
// Reset (synchronous, active low) empties both registers and returns the
// scanner to plain text with mask zero and level one.
// ----------------------------------------------------------------------------
// format_spec_usage_scanner
// Streams a format string and reports the conversions and level it needs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "format_spec_usage_scanner_defines.svh"

module format_spec_usage_scanner (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,   // [7:0] ch
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [fsus_pkg::TDATA_W-1:0]          o_m_tdata    // [30:0] format_mask,
                                                               // [32:31] complexity
);

    logic                          r_in_valid;
    logic [fsus_pkg::CH_W-1:0]     r_in_ch;
    fsus_pkg::t_state              r_state;
    fsus_pkg::t_state              n_state;
    logic                          r_out_valid;
    logic [fsus_pkg::MASK_W-1:0]   r_out_mask;
    logic [fsus_pkg::LEVEL_W-1:0]  r_out_level;

    logic emit;
    logic advance;

    fsus_parser u_parser (
        .i_ch    (r_in_ch),
        .i_state (r_state),
        .o_state (n_state),
        .o_emit  (emit)
    );

    // held word moves on unless it is a result and the output slot is blocked
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= fsus_pkg::STATE_RESET;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch <= i_s_tdata;
        end
        if (advance && emit) begin
            r_out_mask  <= r_state.mask;
            r_out_level <= r_state.level;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(fsus_pkg::TDATA_W - fsus_pkg::MASK_W - fsus_pkg::LEVEL_W){1'b0}},
                         r_out_level, r_out_mask};

    `FSUS_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n,
        advance && emit, r_out_valid, "result word lost")
    `FSUS_ASSERT_NEXT(a_emit_resets_state, i_clk, i_rst_n,
        advance && emit, r_state == fsus_pkg::STATE_RESET, "state not cleared after result")
    `FSUS_ASSERT_IMPL(a_level_nonzero, i_clk, i_rst_n,
        1'b1, r_state.level != '0, "level dropped to zero")
    `FSUS_ASSERT_IMPL(a_stall_on_full, i_clk, i_rst_n,
        r_in_valid && emit && r_out_valid && !i_m_tready, !o_s_tready && !advance,
        "input taken while result blocked")

endmodule

`default_nettype wire

/* src/fsus_conv_lookup.sv */
// ----------------------------------------------------------------------------
// fsus_conv_lookup
// Parallel compare of one byte against all conversion table codes.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_conv_lookup (
    input  wire logic [fsus_pkg::CH_W-1:0] i_ch,
    output fsus_pkg::t_conv_hit            o_hit
);

    // codes are distinct, so at most one entry matches and OR-ing is a mux
    always_comb begin
        o_hit = '0;
        for (int i = 0; i < fsus_pkg::TBL_LEN; i++) begin
            if (fsus_pkg::CONV_TBL[i].code == i_ch) begin
                o_hit.hit        = 1'b1;
                o_hit.level      = o_hit.level | fsus_pkg::CONV_TBL[i].level;
                o_hit.short_mask = o_hit.short_mask | fsus_pkg::CONV_TBL[i].short_mask;
                o_hit.long_mask  = o_hit.long_mask | fsus_pkg::CONV_TBL[i].long_mask;
            end
        end
    end

endmodule

`default_nettype wire

/* src/fsus_parser.sv */
// ----------------------------------------------------------------------------
// fsus_parser
// Next-state logic of the specifier scanner for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_parser (
    input  wire logic [fsus_pkg::CH_W-1:0] i_ch,
    input  fsus_pkg::t_state               i_state,
    output fsus_pkg::t_state               o_state,
    output logic                           o_emit
);

    fsus_pkg::t_conv_hit conv;

    logic is_letter;
    logic is_digit;
    logic is_flag;
    logic is_pct;

    fsus_pkg::t_state st_conv_s;   // on_conv, short masks
    fsus_pkg::t_state st_conv_l;   // on_conv, long masks when long_seen
    fsus_pkg::t_state st_len;      // on_length
    fsus_pkg::t_state st_width;    // width bit marked

    fsus_conv_lookup u_lookup (
        .i_ch  (i_ch),
        .o_hit (conv)
    );

    assign is_letter = (i_ch >= 8'h61 && i_ch <= 8'h7A) || (i_ch >= 8'h41 && i_ch <= 8'h5A);
    assign is_digit  = (i_ch >= 8'h30 && i_ch <= 8'h39);
    assign is_flag   = (i_ch == 8'h2D) || (i_ch == 8'h30) || (i_ch == 8'h2B) ||
                       (i_ch == 8'h20) || (i_ch == 8'h2A) || (i_ch == 8'h2E);
    assign is_pct    = (i_ch == 8'h25);

    always_comb begin
        // conversion byte, short form
        st_conv_s           = i_state;
        st_conv_s.long_seen = 1'b0;
        if (conv.hit) begin
            st_conv_s.mask  = i_state.mask | conv.short_mask;
            st_conv_s.level = (i_state.level < conv.level) ? conv.level : i_state.level;
            st_conv_s.phase = (i_ch == 8'h5B) ? fsus_pkg::PH_BRACKET : fsus_pkg::PH_TEXT;
        end else begin
            // no match: rescan as text
            st_conv_s.phase = is_pct ? fsus_pkg::PH_PCT : fsus_pkg::PH_TEXT;
        end

        st_conv_l = st_conv_s;
        if (conv.hit && i_state.long_seen) begin
            st_conv_l.mask = i_state.mask | conv.long_mask;
        end

        // length modifier, falling back to conversion
        st_len = st_conv_s;
        if (i_ch == 8'h6C) begin
            st_len           = i_state;
            st_len.level     = (i_state.level < fsus_pkg::LEVEL_STD) ? fsus_pkg::LEVEL_STD
                                                                     : i_state.level;
            st_len.long_seen = 1'b1;
            st_len.phase     = fsus_pkg::PH_CONV;
        end else if (i_ch == 8'h68) begin
            st_len       = i_state;
            st_len.phase = fsus_pkg::PH_H1;
        end else if (i_ch == 8'h7A) begin
            st_len           = i_state;
            st_len.long_seen = 1'b0;
            st_len.phase     = fsus_pkg::PH_CONV;
        end

        st_width       = i_state;
        st_width.mask  = i_state.mask | fsus_pkg::WIDTH_BIT;
        st_width.level = (i_state.level < fsus_pkg::LEVEL_STD) ? fsus_pkg::LEVEL_STD
                                                               : i_state.level;
    end

    always_comb begin
        o_emit  = 1'b0;
        o_state = i_state;
        if (i_ch == '0) begin
            o_emit  = 1'b1;
            o_state = fsus_pkg::STATE_RESET;
        end else begin
            unique case (i_state.phase)
                fsus_pkg::PH_PCT: begin
                    if (is_flag) begin
                        o_state       = st_width;
                        o_state.phase = fsus_pkg::PH_FLAGS;
                    end else if (is_digit) begin
                        o_state       = st_width;
                        o_state.phase = fsus_pkg::PH_DIGITS;
                    end else begin
                        o_state = st_len;
                    end
                end
                fsus_pkg::PH_FLAGS: begin
                    if (is_letter) o_state = st_len;
                end
                fsus_pkg::PH_DIGITS: begin
                    if (!(is_digit || i_ch == 8'h2E)) o_state = st_len;
                end
                fsus_pkg::PH_H1: begin
                    if (i_ch == 8'h68) begin
                        o_state.long_seen = 1'b0;
                        o_state.phase     = fsus_pkg::PH_CONV;
                    end else begin
                        o_state = st_conv_s;
                    end
                end
                fsus_pkg::PH_CONV: begin
                    o_state = st_conv_l;
                end
                fsus_pkg::PH_BRACKET: begin
                    if (i_ch == 8'h5D) o_state.phase = fsus_pkg::PH_TEXT;
                end
                default: begin
                    o_state.phase = is_pct ? fsus_pkg::PH_PCT : fsus_pkg::PH_TEXT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
